>>> rtl/core/twbc_pkg.sv
// Shared types and codes for the two-way write-back cache.
// No dependencies.
package twbc_pkg;
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_WB   = 2'd1;
  localparam logic [1:0] KIND_REQ  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [3:0]  size;
    logic [63:0] write_data;
    logic [63:0] fill_data;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] line_address;
    logic [63:0] data;
    logic        last;
    logic [63:0] hit_count;
    logic [63:0] access_count;
  } out_beat_t;
endpackage

>>> rtl/core/twbc_data_ram.sv
// Line data memory, one 64-bit word per entry, registered read.
// Depends on nothing.
module twbc_data_ram #(
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);
  logic [63:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/twbc_tag_ram.sv
// Tag memory: per set, both ways' tag, valid and dirty, registered read.
// Depends on nothing.
module twbc_tag_ram #(
  parameter int SW = 5,
  parameter int EW = 25
) (
  input  logic            clk,
  input  logic            we,
  input  logic [SW-1:0]   waddr,
  input  logic [2*EW-1:0] wdata,
  input  logic [SW-1:0]   raddr,
  output logic [2*EW-1:0] rdata
);
  logic [2*EW-1:0] mem [2**SW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/two_way_write_back_cache.sv
// Two-way set-associative write-back cache, top level.
// Depends on twbc_pkg, twbc_tag_ram, twbc_data_ram.
//
// channel  | ports                   | handshake
// input    | start, in_beat, busy    | start & !busy
// result   | out_valid, out_beat     | out_valid, one cycle, never held off
//
// After reset release busy stays high while the tags of all NSETS sets (32 by default) clear.
// An access keeps busy high through the lookup (S_TRD, S_CHK, S_FILL), S_BRD or S_BRD2,
// S_BYTE and S_BWR per byte moved, and S_DONE; the done beat shows in the first cycle with
// busy low. Each further line part repeats the lookup. A miss issues the fill request after
// the lookup; a dirty victim first sends LINE_BYTES/8 writeback beats. Fill beats are taken
// back to back with busy low, and the last one moves the waiting bytes as a hit does.
module two_way_write_back_cache #(
  parameter int CACHE_BYTES = 4096,
  parameter int LINE_BYTES  = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  twbc_pkg::in_beat_t  in_beat,
  output logic                busy,
  output logic                out_valid,
  output twbc_pkg::out_beat_t out_beat
);
  import twbc_pkg::*;

  localparam int NSETS = CACHE_BYTES / LINE_BYTES / 2;
  localparam int SW    = $clog2(NSETS);
  localparam int OW    = $clog2(LINE_BYTES);
  localparam int WW    = OW - 3;
  localparam int WORDS = LINE_BYTES / 8;
  localparam int TW    = 32 - OW - SW;
  localparam int EW    = TW + 2;
  localparam int AW    = SW + 1 + WW;
  localparam int CW    = (WW > 3) ? WW + 1 : 4;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_TRD  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_BYTE = 4'd4;
  localparam logic [3:0] S_BWR  = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_REQ  = 4'd7;
  localparam logic [3:0] S_FILL = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;
  localparam logic [3:0] S_BRD  = 4'd10;
  localparam logic [3:0] S_WBRD = 4'd11;
  localparam logic [3:0] S_BRD2 = 4'd12;

  logic [3:0]  state_r, state_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [3:0]  size_r, size_nxt;
  logic [63:0] wbytes_r, wbytes_nxt;
  logic [63:0] rbytes_r, rbytes_nxt;
  logic [3:0]  gath_r, gath_nxt;
  logic        is_wr_r, is_wr_nxt;
  logic        way_r, way_nxt;
  logic        miss_r, miss_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0] hits_r, hits_nxt;
  logic [63:0] accs_r, accs_nxt;
  logic [NSETS-1:0] lru_r, lru_nxt;
  logic [2*EW-1:0]  tags_r, tags_nxt;
  logic        ov_r, ov_nxt;
  out_beat_t   ob_r, ob_nxt;

  logic            t_we;
  logic [SW-1:0]   t_waddr, t_raddr;
  logic [2*EW-1:0] t_wdata, t_rdata;
  logic            d_we;
  logic [AW-1:0]   d_waddr, d_raddr;
  logic [63:0]     d_wdata, d_rdata;

  twbc_tag_ram #(.SW(SW), .EW(EW)) u_tag (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata));
  twbc_data_ram #(.AW(AW)) u_data (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata));

  logic [SW-1:0] set_w;
  logic [TW-1:0] tag_w;
  logic [OW-1:0] off_w;
  logic [OW:0]   room_w;
  logic [3:0]    plen_w;
  logic [EW-1:0] e0, e1, ev;
  logic          h0, h1, vict;
  logic [2:0]    bsel;
  logic [7:0]    rb;
  logic [AW-1:0] baddr;

  assign set_w  = addr_r[OW +: SW];
  assign tag_w  = addr_r[31 -: TW];
  assign off_w  = addr_r[OW-1:0];
  assign room_w = (OW+1)'(LINE_BYTES) - {1'b0, off_w};
  assign plen_w = ({{(OW-3){1'b0}}, size_r} > room_w) ? room_w[3:0] : size_r;
  assign e0     = tags_r[EW-1:0];
  assign e1     = tags_r[2*EW-1:EW];
  assign h0     = e0[0] && e0[EW-1:2] == tag_w;
  assign h1     = e1[0] && e1[EW-1:2] == tag_w;
  assign vict   = e1[0] ? ~lru_r[set_w] : 1'b1;
  assign ev     = vict ? e1 : e0;
  assign bsel   = off_w[2:0];
  assign baddr  = {set_w, way_r, off_w[OW-1:3]};
  assign rb     = d_rdata[{bsel, 3'b000} +: 8];

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_beat  = ob_r;

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    size_nxt   = size_r;
    wbytes_nxt = wbytes_r;
    rbytes_nxt = rbytes_r;
    gath_nxt   = gath_r;
    is_wr_nxt  = is_wr_r;
    way_nxt    = way_r;
    miss_nxt   = miss_r;
    cnt_nxt    = cnt_r;
    hits_nxt   = hits_r;
    accs_nxt   = accs_r;
    lru_nxt    = lru_r;
    tags_nxt   = tags_r;
    ov_nxt     = 1'b0;
    ob_nxt     = '0;
    t_we       = 1'b0;
    t_waddr    = set_w;
    t_wdata    = tags_r;
    t_raddr    = set_w;
    d_we       = 1'b0;
    d_waddr    = baddr;
    d_wdata    = d_rdata;
    d_raddr    = baddr;
    unique case (state_r)
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = addr_r[SW-1:0];
        t_wdata = '0;
        addr_nxt = addr_r + 32'd1;
        if (addr_r[SW-1:0] == SW'(NSETS - 1)) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_beat.action == ACT_READ || in_beat.action == ACT_WRITE) begin
            if (!miss_r) begin
              addr_nxt   = in_beat.address;
              size_nxt   = (in_beat.size == 4'd0) ? 4'd1 :
                           (in_beat.size > 4'd8) ? 4'd8 : in_beat.size;
              wbytes_nxt = in_beat.write_data;
              rbytes_nxt = '0;
              gath_nxt   = '0;
              is_wr_nxt  = (in_beat.action == ACT_WRITE);
              state_nxt  = S_TRD;
            end
          end else if (in_beat.action == ACT_FILL && miss_r) begin
            d_we    = 1'b1;
            d_waddr = {set_w, way_r, cnt_r[WW-1:0]};
            d_wdata = in_beat.fill_data;
            cnt_nxt = cnt_r + 1'b1;
            if (cnt_r == CW'(WORDS - 1)) begin
              cnt_nxt  = '0;
              miss_nxt = 1'b0;
              lru_nxt[set_w] = way_r;
              t_we = 1'b1;
              if (way_r) t_wdata[2*EW-1:EW] = {tag_w, 2'b01};
              else       t_wdata[EW-1:0]    = {tag_w, 2'b01};
              tags_nxt  = t_wdata;
              state_nxt = S_BRD;
            end
          end
        end
      end
      S_TRD: state_nxt = S_CHK;
      S_CHK: begin
        tags_nxt  = t_rdata;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        accs_nxt = accs_r + 64'd1;
        if (h0 || h1) begin
          hits_nxt = hits_r + 64'd1;
          way_nxt  = h1 && !h0 ? 1'b1 : 1'b0;
          lru_nxt[set_w] = way_nxt;
          state_nxt = S_BRD;
        end else begin
          way_nxt = vict;
          cnt_nxt = '0;
          state_nxt = (ev[0] && ev[1]) ? S_WBRD : S_REQ;
        end
      end
      S_BRD: begin
        size_nxt = size_r;
        cnt_nxt  = CW'(plen_w);
        state_nxt = S_BYTE;
      end
      S_BYTE: begin
        if (is_wr_r) begin
          d_we    = 1'b1;
          d_wdata[{bsel, 3'b000} +: 8] = wbytes_r[7:0];
          wbytes_nxt = wbytes_r >> 8;
          state_nxt  = S_BWR;
        end else begin
          if (gath_r < 4'd8) rbytes_nxt[{gath_r[2:0], 3'b000} +: 8] = rb;
          state_nxt = S_BWR;
        end
      end
      S_BWR: begin
        if (is_wr_r) begin
          t_we = 1'b1;
          if (way_r) t_wdata[EW+1] = 1'b1;
          else       t_wdata[1]    = 1'b1;
          tags_nxt = t_wdata;
        end
        addr_nxt = addr_r + 32'd1;
        size_nxt = size_r - 4'd1;
        gath_nxt = gath_r + 4'd1;
        cnt_nxt  = cnt_r - 1'b1;
        if (size_r == 4'd1) state_nxt = S_DONE;
        else if (cnt_r == CW'(1)) state_nxt = S_TRD;
        else state_nxt = S_BRD2;
      end
      S_BRD2: state_nxt = S_BYTE;
      S_WBRD: begin
        d_raddr   = {set_w, way_r, cnt_r[WW-1:0]};
        state_nxt = S_WB;
      end
      S_WB: begin
        ov_nxt = 1'b1;
        ob_nxt.kind = KIND_WB;
        ob_nxt.line_address = {ev[EW-1:2], set_w, {OW{1'b0}}};
        ob_nxt.data = d_rdata;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(WORDS - 1)) begin
          cnt_nxt = '0;
          state_nxt = S_REQ;
        end else state_nxt = S_WBRD;
      end
      S_REQ: begin
        ov_nxt = 1'b1;
        ob_nxt.kind = KIND_REQ;
        ob_nxt.line_address = {addr_r[31:OW], {OW{1'b0}}};
        ob_nxt.last = 1'b1;
        t_we = 1'b1;
        if (way_r) t_wdata[2*EW-1:EW] = '0;
        else       t_wdata[EW-1:0]    = '0;
        tags_nxt  = t_wdata;
        miss_nxt  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_IDLE;
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        ob_nxt.kind = KIND_DONE;
        ob_nxt.data = is_wr_r ? 64'd0 : rbytes_r;
        ob_nxt.last = 1'b1;
        ob_nxt.hit_count = hits_r;
        ob_nxt.access_count = accs_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      addr_r  <= '0;
      size_r  <= '0;
      miss_r  <= 1'b0;
      cnt_r   <= '0;
      hits_r  <= '0;
      accs_r  <= '0;
      lru_r   <= '0;
      ov_r    <= 1'b0;
      way_r   <= 1'b0;
      is_wr_r <= 1'b0;
      gath_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      size_r  <= size_nxt;
      miss_r  <= miss_nxt;
      cnt_r   <= cnt_nxt;
      hits_r  <= hits_nxt;
      accs_r  <= accs_nxt;
      lru_r   <= lru_nxt;
      ov_r    <= ov_nxt;
      way_r   <= way_nxt;
      is_wr_r <= is_wr_nxt;
      gath_r  <= gath_nxt;
    end
    wbytes_r <= wbytes_nxt;
    rbytes_r <= rbytes_nxt;
    tags_r   <= tags_nxt;
    ob_r     <= ob_nxt;
  end
endmodule

>>> rtl/core/twbc_checker.sv
// Port-level checks for the two-way write-back cache, bound to the top level.
// Depends on twbc_pkg and two_way_write_back_cache.
module twbc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                busy,
  input logic                out_valid,
  input twbc_pkg::out_beat_t out_beat
);
  import twbc_pkg::*;

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_beat.kind != 2'd3)
    else $error("bad result kind");
  a_wb_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.kind == KIND_WB |-> !out_beat.last)
    else $error("writeback beat marked last");
  a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.kind == KIND_WB |-> busy)
    else $error("input open during writeback");
  a_req_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.kind == KIND_REQ |-> out_beat.last)
    else $error("fill request not last");
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_beat.kind != KIND_DONE |-> out_beat.line_address[3:0] == 4'd0)
    else $error("line address unaligned");
endmodule

bind two_way_write_back_cache twbc_checker u_twbc_checker (
  .clk, .rst_n, .busy, .out_valid, .out_beat);
